// ===== hw/rtl/locb_pkg.sv =====
// Shared types and constants for the LRU object cache metadata engine.
`default_nettype none
package locb_pkg;
   localparam int SIZE_W  = 21;
   localparam int STAMP_W = 48;
   localparam int IDX_W   = 10;
   localparam int CNT_W   = 8;
   localparam int OUT_IDX_W = 7;
   localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1024 * 1024);
   localparam logic [SIZE_W-1:0] MAX_RESET = SIZE_W'(100 * 1024);
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_STORE  = 1'b1;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_MAX_OBJ  = 1'b1;

   // Search record that travels down the cell chain.
   typedef struct packed {
      logic               active;
      logic               match_found;
      logic [IDX_W-1:0]   match_idx;
      logic [SIZE_W-1:0]  match_size;
      logic               free_found;
      logic [IDX_W-1:0]   free_idx;
      logic               old_found;
      logic [IDX_W-1:0]   old_idx;
      logic [STAMP_W-1:0] old_stamp;
      logic [SIZE_W-1:0]  old_size;
   } sweep_rec_type;

   // Update broadcast to all cells.
   typedef struct packed {
      logic               drop;
      logic               write;
      logic               touch;
      logic [IDX_W-1:0]   idx;
      logic [SIZE_W-1:0]  size;
      logic [STAMP_W-1:0] stamp;
   } cell_cmd_type;
endpackage
`default_nettype wire

// ===== hw/rtl/locb_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface locb_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] key_tag;
   logic [20:0] obj_size;
   modport source (output valid, req_type, key_tag, obj_size, input ready);
   modport sink (input valid, req_type, key_tag, obj_size, output ready);
endinterface

interface locb_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [6:0]  slot_index;
   logic [20:0] hit_size;
   logic        stored;
   logic [7:0]  evicted_count;
   modport source (output valid, hit, slot_index, hit_size, stored, evicted_count,
                   input ready);
   modport sink (input valid, hit, slot_index, hit_size, stored, evicted_count,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lru_object_cache_with_byte_budget.sv =====
// Top level: request control, byte budget, registers and the chain of slot cells.
// A request is taken when the block is idle and no response is waiting. Every
// search is one pass of a record down the chain of SLOTS cells, each of which
// registers it. A lookup takes one pass. A store
// that is not ignored takes one pass for the same-key check, one for each budget
// eviction plus one more, one for the free slot and one more if a slot had to be
// freed: at most (3 + evictions) passes. An ignored store answers without a pass.
// No clearing pass after reset.
`default_nettype none
module lru_object_cache_with_byte_budget
   import locb_pkg::*;
#(
   parameter int SLOTS    = 128,
   parameter int TAG_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   locb_req_if.sink         req_ch,
   locb_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_RESP  = 3'b100
   } state_type;

   typedef enum logic [4:0] {
      PH_LOOK  = 5'b00001,
      PH_MATCH = 5'b00010,
      PH_FIT   = 5'b00100,
      PH_FREE  = 5'b01000,
      PH_FREE2 = 5'b10000
   } phase_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic                launch_ff, launch_in;
   logic [TAG_BITS-1:0] qtag_ff, qtag_in;
   logic [SIZE_W-1:0]   qsize_ff, qsize_in;
   logic [SIZE_W-1:0]   bytes_ff, bytes_in;
   logic [STAMP_W-1:0]  clock_ff, clock_in;
   logic [SIZE_W-1:0]   cap_ff, max_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                hit_ff, hit_in;
   logic [OUT_IDX_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0]   hsize_ff, hsize_in;
   logic                stored_ff, stored_in;
   logic [CNT_W-1:0]    evict_ff, evict_in;

   sweep_rec_type       chain [SLOTS+1];
   sweep_rec_type       res;
   cell_cmd_type        cmd;
   logic                fits, over, ignore, csr_wr;
   logic [STAMP_W-1:0]  next_stamp;
   logic [CNT_W-1:0]    cnt_inc;

   assign res        = chain[SLOTS];
   assign next_stamp = clock_ff + STAMP_W'(1);
   assign cnt_inc    = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign fits       = ({1'b0, bytes_ff} + {1'b0, qsize_ff}) <= {1'b0, cap_ff};
   assign over       = !fits;
   assign ignore     = (req_ch.obj_size == '0) || (req_ch.obj_size > max_ff)
                       || (req_ch.obj_size > cap_ff);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = (state_ff == ST_RESP);
   assign rsp_ch.hit           = hit_ff;
   assign rsp_ch.slot_index    = idx_ff;
   assign rsp_ch.hit_size      = hsize_ff;
   assign rsp_ch.stored        = stored_ff;
   assign rsp_ch.evicted_count = evict_ff;

   assign chain[0] = '{active: launch_ff, default: '0};

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      locb_cell #(.TAG_BITS(TAG_BITS), .CELL_IDX(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .query_tag (qtag_ff),
         .rec_in    (chain[g]),
         .rec_out   (chain[g+1])
      );
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      launch_in = 1'b0;
      qtag_in   = qtag_ff;
      qsize_in  = qsize_ff;
      bytes_in  = bytes_ff;
      clock_in  = clock_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      idx_in    = idx_ff;
      hsize_in  = hsize_ff;
      stored_in = stored_ff;
      evict_in  = evict_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               qtag_in   = req_ch.key_tag[TAG_BITS-1:0];
               qsize_in  = req_ch.obj_size;
               cnt_in    = '0;
               hit_in    = 1'b0;
               idx_in    = '0;
               hsize_in  = '0;
               stored_in = 1'b0;
               evict_in  = '0;
               if (req_ch.req_type == REQ_LOOKUP) begin
                  phase_in  = PH_LOOK;
                  launch_in = 1'b1;
                  state_in  = ST_SWEEP;
               end else if (ignore) begin
                  state_in = ST_RESP;
               end else begin
                  phase_in  = PH_MATCH;
                  launch_in = 1'b1;
                  state_in  = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (res.active) begin
               case (phase_ff)
                  PH_LOOK: begin
                     if (res.match_found) begin
                        cmd.touch = 1'b1;
                        cmd.idx   = res.match_idx;
                        cmd.stamp = next_stamp;
                        clock_in  = next_stamp;
                        hit_in    = 1'b1;
                        idx_in    = res.match_idx[OUT_IDX_W-1:0];
                        hsize_in  = res.match_size;
                     end
                     state_in = ST_RESP;
                  end
                  PH_MATCH: begin
                     if (res.match_found) begin
                        cmd.drop = 1'b1;
                        cmd.idx  = res.match_idx;
                        bytes_in = bytes_ff - res.match_size;
                        cnt_in   = cnt_inc;
                     end
                     phase_in  = PH_FIT;
                     launch_in = 1'b1;
                  end
                  PH_FIT: begin
                     // evict oldest until the object fits or nothing is left
                     if (over && res.old_found) begin
                        cmd.drop = 1'b1;
                        cmd.idx  = res.old_idx;
                        bytes_in = bytes_ff - res.old_size;
                        cnt_in   = cnt_inc;
                     end else begin
                        phase_in = PH_FREE;
                     end
                     launch_in = 1'b1;
                  end
                  PH_FREE, PH_FREE2: begin
                     if (res.free_found) begin
                        if (fits) begin
                           cmd.write = 1'b1;
                           cmd.idx   = res.free_idx;
                           cmd.size  = qsize_ff;
                           cmd.stamp = next_stamp;
                           clock_in  = next_stamp;
                           bytes_in  = bytes_ff + qsize_ff;
                           idx_in    = res.free_idx[OUT_IDX_W-1:0];
                           stored_in = 1'b1;
                        end
                        evict_in = cnt_ff;
                        state_in = ST_RESP;
                     end else if (phase_ff == PH_FREE && res.old_found) begin
                        cmd.drop  = 1'b1;
                        cmd.idx   = res.old_idx;
                        bytes_in  = bytes_ff - res.old_size;
                        cnt_in    = cnt_inc;
                        phase_in  = PH_FREE2;
                        launch_in = 1'b1;
                     end else begin
                        evict_in = cnt_ff;
                        state_in = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_OBJ) ? {11'b0, max_ff} : {11'b0, cap_ff};

   always_ff @(posedge clock) begin
      qtag_ff   <= qtag_in;
      qsize_ff  <= qsize_in;
      cnt_ff    <= cnt_in;
      hit_ff    <= hit_in;
      idx_ff    <= idx_in;
      hsize_ff  <= hsize_in;
      stored_ff <= stored_in;
      evict_ff  <= evict_in;
      phase_ff  <= phase_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
         bytes_ff  <= '0;
         clock_ff  <= '0;
         cap_ff    <= CAP_RESET;
         max_ff    <= MAX_RESET;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         bytes_ff  <= bytes_in;
         clock_ff  <= clock_in;
         if (csr_wr && csr_paddr[2] == REG_CAPACITY) begin
            cap_ff <= csr_pwdata[SIZE_W-1:0];
         end
         if (csr_wr && csr_paddr[2] == REG_MAX_OBJ) begin
            max_ff <= csr_pwdata[SIZE_W-1:0];
         end
      end
   end

`ifndef SYNTH
   a_sweep_only_in_search: assert property (@(posedge clock) disable iff (reset)
      res.active |-> state_ff == ST_SWEEP)
      else $error("search record left chain outside search");
   a_launch_from_search: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> state_ff == ST_SWEEP)
      else $error("search launched while not searching");
   a_store_in_budget: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_RESP) && stored_ff |-> {1'b0, bytes_ff} <= {1'b0, cap_ff})
      else $error("byte budget exceeded after store");
   a_lookup_no_evict: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && hit_ff |-> evict_ff == '0 && !stored_ff)
      else $error("lookup hit reports store fields");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/locb_cell.sv =====
// One cache slot: holds its metadata and folds itself into the passing search record.
`default_nettype none
module locb_cell
   import locb_pkg::*;
#(
   parameter int TAG_BITS = 64,
   parameter int CELL_IDX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_cmd_type        cmd,
   input  wire logic [TAG_BITS-1:0] query_tag,
   input  wire sweep_rec_type       rec_in,
   output      sweep_rec_type       rec_out
);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                valid_ff, valid_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   sweep_rec_type       rec_ff, rec_in_next;
   logic                sel;

   assign sel = (cmd.idx == MY_IDX);

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      size_in  = size_ff;
      stamp_in = stamp_ff;
      if (sel && cmd.drop) begin
         valid_in = 1'b0;
      end
      if (sel && cmd.write) begin
         valid_in = 1'b1;
         tag_in   = query_tag;
         size_in  = cmd.size;
         stamp_in = cmd.stamp;
      end
      if (sel && cmd.touch) begin
         stamp_in = cmd.stamp;
      end
   end

   always_comb begin
      rec_in_next = rec_in;
      if (rec_in.active) begin
         if (valid_ff) begin
            if (!rec_in.match_found && tag_ff == query_tag) begin
               rec_in_next.match_found = 1'b1;
               rec_in_next.match_idx   = MY_IDX;
               rec_in_next.match_size  = size_ff;
            end
            // strict compare keeps the lower slot on equal stamps
            if (!rec_in.old_found || stamp_ff < rec_in.old_stamp) begin
               rec_in_next.old_found = 1'b1;
               rec_in_next.old_idx   = MY_IDX;
               rec_in_next.old_stamp = stamp_ff;
               rec_in_next.old_size  = size_ff;
            end
         end else if (!rec_in.free_found) begin
            rec_in_next.free_found = 1'b1;
            rec_in_next.free_idx   = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      size_ff  <= size_in;
      stamp_ff <= stamp_in;
      rec_ff   <= rec_in_next;
      if (reset) begin
         valid_ff      <= 1'b0;
         rec_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rec_out = rec_ff;
endmodule
`default_nettype wire
